// ===== rtl/core/bnib_pkg.sv =====
// package for the bus node id binder
// holds table sizes, identity widths and the probe result type
// no dependencies
`timescale 1ns / 1ps

package bnib_pkg;

  localparam int NUM_IDS      = 254;
  localparam int SERIAL_BITS  = 32;
  localparam int PRODUCT_BITS = 16;
  localparam int VENDOR_BITS  = 16;

  localparam int ID_W    = 8;
  localparam int SLOT_W  = $clog2(NUM_IDS);
  localparam int CNT_W   = $clog2(NUM_IDS + 1);
  localparam int IDENT_W = SERIAL_BITS + PRODUCT_BITS + VENDOR_BITS;

  localparam logic [ID_W-1:0] ID_FIRST = ID_W'(1);
  localparam logic [ID_W-1:0] ID_LAST  = ID_W'(NUM_IDS);

  typedef logic [IDENT_W-1:0] ident_t;

  // outcome of one bind transaction, from the sequencer to the top level
  typedef struct packed {
    logic            done;
    logic            fail;
    logic [ID_W-1:0] id;
  } probe_res_t;

endpackage

// ===== rtl/core/bnib_owner_ram.sv =====
// owner identity store of the bus node id binder
// single write port, single registered read port; no dependencies
`timescale 1ns / 1ps

module bnib_owner_ram #(
  parameter int DEPTH = 254,
  parameter int WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/core/bnib_probe_seq.sv =====
// probe sequencer of the bus node id binder: one table probe per cycle,
// shared identity comparator, used marks and the owner identity ram
// depends on bnib_pkg and bnib_owner_ram
`timescale 1ns / 1ps

module bnib_probe_seq
  import bnib_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            go_i,
  input  logic [ID_W-1:0] start_id_i,
  input  ident_t          ident_i,
  output probe_res_t      res_o
);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  state_e            state_q;
  logic [ID_W-1:0]   id_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              chk_vld_q;
  logic              chk_last_q;
  logic              chk_used_q;
  logic [ID_W-1:0]   chk_id_q;
  logic [NUM_IDS-1:0] used_q;

  logic [ID_W-1:0]   id_m1;
  logic [SLOT_W-1:0] issue_slot;
  logic [ID_W-1:0]   chk_m1;
  logic [SLOT_W-1:0] chk_slot;
  logic [ID_W-1:0]   id_next;
  logic              issue;
  logic              same_owner;
  logic              hit;
  logic              fail;
  logic              grant_new;
  ident_t            owner_rd;

  assign id_m1      = id_q - ID_FIRST;
  assign issue_slot = id_m1[SLOT_W-1:0];
  assign chk_m1     = chk_id_q - ID_FIRST;
  assign chk_slot   = chk_m1[SLOT_W-1:0];
  assign id_next    = (id_q == ID_LAST) ? ID_FIRST : id_q + ID_FIRST;
  assign issue      = (state_q == S_SCAN) && (cnt_q < CNT_W'(NUM_IDS));

  // shared comparator: probed owner against the requester
  assign same_owner = (owner_rd == ident_i);
  assign hit        = chk_vld_q && (!chk_used_q || same_owner);
  assign fail       = chk_vld_q && !hit && chk_last_q;
  assign grant_new  = chk_vld_q && !chk_used_q;

  assign res_o.done = hit || fail;
  assign res_o.fail = fail;
  assign res_o.id   = chk_id_q;

  bnib_owner_ram #(
    .DEPTH (NUM_IDS),
    .WIDTH (IDENT_W)
  ) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (grant_new),
    .waddr_i (chk_slot),
    .wdata_i (ident_i),
    .raddr_i (issue_slot),
    .rdata_o (owner_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      id_q       <= ID_FIRST;
      cnt_q      <= '0;
      chk_vld_q  <= 1'b0;
      chk_last_q <= 1'b0;
      chk_used_q <= 1'b0;
      chk_id_q   <= ID_FIRST;
      used_q     <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          chk_vld_q <= 1'b0;
          if (go_i) begin
            id_q    <= start_id_i;
            cnt_q   <= '0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit || fail) begin
            chk_vld_q <= 1'b0;
            state_q   <= S_IDLE;
            if (grant_new) begin
              used_q[chk_slot] <= 1'b1;
            end
          end else begin
            chk_vld_q <= issue;
            if (issue) begin
              chk_id_q   <= id_q;
              chk_used_q <= used_q[issue_slot];
              chk_last_q <= (cnt_q == CNT_W'(NUM_IDS - 1));
              id_q       <= id_next;
              cnt_q      <= cnt_q + CNT_W'(1);
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_done_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.done |-> state_q == S_SCAN)
    else $error("probe result outside a scan");

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(NUM_IDS))
    else $error("probe count beyond table size");

  a_grant_marks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.done && grant_new) |=> used_q[$past(chk_slot)])
    else $error("granted free id not marked used");

  a_id_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_vld_q |-> (chk_id_q >= ID_FIRST) && (chk_id_q <= ID_LAST))
    else $error("probed id outside 1..NUM_IDS");

endmodule

// ===== rtl/core/bus_node_id_binder_unit.sv =====
// top level of the bus node id binder
// request capture, start id selection and result registers
// depends on bnib_pkg and bnib_probe_seq
`timescale 1ns / 1ps

// usage:
// - a bind transaction is taken at a rising edge where start is high and
//   busy is low; wanted_id_i and the requester identity are captured then
// - busy stays high while the table is probed, one id per cycle, upward from
//   the wanted id with wrap from NUM_IDS back to 1; ids 0 and 255 are never
//   probed, and a wanted id of 0 or above NUM_IDS starts the probe at 1
// - the first id that is free or already owned by the same identity is
//   granted; a free id is recorded as owned by the requester
// - the probe ends at the first grant, or after all NUM_IDS ids when the table
//   is full; the single owner ram read port allows one probe per cycle
// - the result is on bind_status_o / granted_id_o for exactly one cycle with
//   done_o high; busy is already low in that cycle, so the next transaction
//   may start there; the receiver cannot stall the result
// - reset clears all used marks at once; owner identities are only read
//   behind a set used mark, so the ram itself is never cleared
module bus_node_id_binder_unit
  import bnib_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [ID_W-1:0]         wanted_id_i,
  input  logic [31:0]             requester_serial_i,
  input  logic [15:0]             requester_product_i,
  input  logic [15:0]             requester_vendor_i,
  output logic                    done_o,
  output logic                    bind_status_o,
  output logic [ID_W-1:0]         granted_id_o
);

  logic            accept;
  logic            busy_q;
  logic [ID_W-1:0] start_id;
  ident_t          ident_d;
  ident_t          ident_q;
  probe_res_t      res;
  logic            done_q;
  logic            status_q;
  logic [ID_W-1:0] id_q;

  assign accept = start && !busy_q;
  assign busy   = busy_q;

  // identity cut to the configured widths
  assign ident_d = {requester_serial_i[SERIAL_BITS-1:0],
                    requester_product_i[PRODUCT_BITS-1:0],
                    requester_vendor_i[VENDOR_BITS-1:0]};

  // no preference or out of range starts at the first id
  always_comb begin
    if (wanted_id_i inside {[ID_FIRST : ID_LAST]}) begin
      start_id = wanted_id_i;
    end else begin
      start_id = ID_FIRST;
    end
  end

  // requester identity held for the whole probe
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ident_q <= ident_d;
    end
  end

  bnib_probe_seq u_probe_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (accept),
    .start_id_i (start_id),
    .ident_i    (ident_q),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= res.done;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (res.done) begin
        busy_q <= 1'b0;
      end
    end
  end

  // result payload, zero id on failure
  always_ff @(posedge clk_i) begin
    if (res.done) begin
      status_q <= res.fail;
      id_q     <= res.fail ? '0 : res.id;
    end
  end

  assign done_o        = done_q;
  assign bind_status_o = status_q;
  assign granted_id_o  = id_q;

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench for bus_node_id_binder_unit
// predicts every bind transaction from its own copy of the id table
// depends on bnib_pkg and the bus_node_id_binder_unit rtl
`timescale 1ns / 1ps

module tb_top;
  import bnib_pkg::*;

  // bind_status codes
  localparam logic BIND_GRANTED = 1'b0;
  localparam logic BIND_NO_ID   = 1'b1;

  localparam int unsigned RANDOM_BINDS = 500;
  localparam int unsigned NUM_PHASES   = 4;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = NUM_IDS + 8;

  typedef struct packed {
    logic [31:0] serial;
    logic [15:0] product;
    logic [15:0] vendor;
  } requester_t;

  typedef struct packed {
    logic            fail;
    logic [ID_W-1:0] id;
  } bind_outcome_t;

  // mirror of the id table, plus the grants still owed by the block
  class node_id_table;
    bit              used[1:NUM_IDS];
    ident_t          owner[1:NUM_IDS];
    bind_outcome_t   grants_due[$];
    int unsigned     mismatches;
    int unsigned     requests;
    int unsigned     fresh_grants;
    int unsigned     repeat_grants;
    int unsigned     refusals;
    int unsigned     full_at;

    function new();
      for (int i = 1; i <= NUM_IDS; i++) used[i] = 1'b0;
      mismatches = 0;
      requests = 0;
      fresh_grants = 0;
      repeat_grants = 0;
      refusals = 0;
      full_at = 0;
    endfunction

    // walk the table from the wanted id and queue the outcome
    function void note_request(logic [ID_W-1:0] wanted, requester_t who);
      ident_t        ident;
      int unsigned   first;
      int unsigned   id;
      int unsigned   taken;
      bit            found;
      bind_outcome_t due;
      ident = {who.serial[SERIAL_BITS-1:0], who.product[PRODUCT_BITS-1:0],
               who.vendor[VENDOR_BITS-1:0]};
      first = (wanted >= 1 && wanted <= NUM_IDS) ? wanted : 1;
      found = 1'b0;
      due.fail = BIND_NO_ID;
      due.id = '0;
      requests++;
      for (int k = 0; k < NUM_IDS && !found; k++) begin
        id = first + k;
        if (id > NUM_IDS) id -= NUM_IDS;
        if (!used[id]) begin
          used[id] = 1'b1;
          owner[id] = ident;
          found = 1'b1;
          fresh_grants++;
        end else if (owner[id] == ident) begin
          found = 1'b1;
          repeat_grants++;
        end
        if (found) begin
          due.fail = BIND_GRANTED;
          due.id = ID_W'(id);
        end
      end
      if (!found) refusals++;
      taken = 0;
      for (int i = 1; i <= NUM_IDS; i++) taken += used[i];
      if (taken == NUM_IDS && full_at == 0) full_at = requests;
      grants_due.push_back(due);
    endfunction

    task flag_mismatch(string what);
      mismatches++;
      if (mismatches <= 20) $display("[%0t] error: %s", $realtime, what);
    endtask

    task check_result(logic status, logic [ID_W-1:0] id);
      bind_outcome_t due;
      if (grants_due.size() == 0) begin
        flag_mismatch($sformatf("result with nothing pending: status %0b id %0d", status, id));
      end else begin
        due = grants_due.pop_front();
        if (status !== due.fail)
          flag_mismatch($sformatf("bind_status %0b, wanted %0b (id %0d)", status, due.fail,
                                  due.id));
        if (id !== due.id)
          flag_mismatch($sformatf("granted_id %0d, wanted %0d", id, due.id));
      end
    endtask
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            start;
  logic            busy;
  logic [ID_W-1:0] wanted_id_i;
  logic [31:0]     requester_serial_i;
  logic [15:0]     requester_product_i;
  logic [15:0]     requester_vendor_i;
  logic            done_o;
  logic            bind_status_o;
  logic [ID_W-1:0] granted_id_o;

  node_id_table    id_table = new();
  int unsigned     idle_pct;
  int unsigned     quiet_cycles;
  requester_t      known_ids[$];

  bus_node_id_binder_unit dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .wanted_id_i         (wanted_id_i),
    .requester_serial_i  (requester_serial_i),
    .requester_product_i (requester_product_i),
    .requester_vendor_i  (requester_vendor_i),
    .done_o              (done_o),
    .bind_status_o       (bind_status_o),
    .granted_id_o        (granted_id_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // sample both sides at the edge; a transaction and a result may share a cycle,
  // the result always belongs to an older transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy)
        id_table.note_request(wanted_id_i, '{requester_serial_i, requester_product_i,
                                             requester_vendor_i});
      if (done_o) id_table.check_result(bind_status_o, granted_id_o);
    end
  end

  // watchdog: a full-table probe plus the longest sender gap stays far below this
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("bus_node_id_binder_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one bind transaction, after an optional idle gap, and hold it until taken;
  // start is written once per edge so back-to-back transactions keep it high
  task automatic send_bind(input logic [ID_W-1:0] want, input requester_t who);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(99) < idle_pct)
      gap = ($urandom_range(7) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 6);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start               <= 1'b1;
    wanted_id_i         <= want;
    requester_serial_i  <= who.serial;
    requester_product_i <= who.product;
    requester_vendor_i  <= who.vendor;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  initial begin
    int unsigned idle_by_phase[NUM_PHASES];
    requester_t  who;
    logic [ID_W-1:0] want;
    int unsigned pick;

    // phase 2 would stall the receiver, but results cannot be held off,
    // so it runs without sender gaps
    idle_by_phase = '{0, 48, 0, 11};
    rst_ni              = 1'b0;
    start               = 1'b0;
    wanted_id_i         = '0;
    requester_serial_i  = '0;
    requester_product_i = '0;
    requester_vendor_i  = '0;
    idle_pct            = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: no-preference ids, the top id with wrap, repeat owners,
    // near-miss identities and field extremes
    send_bind(8'd0,   '{32'h0000_0000, 16'h0000, 16'h0000});
    send_bind(8'd255, '{32'hffff_ffff, 16'hffff, 16'hffff});
    send_bind(ID_LAST, '{32'h1234_5678, 16'h0001, 16'h8000});
    send_bind(ID_LAST, '{32'h8000_0000, 16'h8000, 16'h0001});
    send_bind(8'd0,   '{32'h0000_0000, 16'h0000, 16'h0000});
    send_bind(ID_LAST, '{32'h1234_5678, 16'h0001, 16'h8000});
    send_bind(ID_FIRST, '{32'h1234_5678, 16'h0001, 16'h8000});
    send_bind(ID_FIRST, '{32'h0000_0000, 16'h0000, 16'h0001});
    send_bind(8'd2,   '{32'hffff_ffff, 16'hffff, 16'hffff});
    send_bind(8'd2,   '{32'hffff_ffff, 16'hffff, 16'hfffe});
    send_bind(8'd128, '{32'h5555_5555, 16'haaaa, 16'h5555});
    send_bind(8'd127, '{32'haaaa_aaaa, 16'h5555, 16'haaaa});
    send_bind(8'd128, '{32'h0000_0001, 16'h0000, 16'h0000});
    send_bind(8'd128, '{32'h5555_5555, 16'haaaa, 16'h5555});
    send_bind(8'd253, '{32'h7fff_ffff, 16'h7fff, 16'h7fff});
    send_bind(8'd255, '{32'h7fff_ffff, 16'h7fff, 16'h7fff});
    send_bind(8'd0,   '{32'h8000_0000, 16'h8000, 16'h0001});

    // random: mostly new requesters so the table fills and later refuses,
    // the rest repeat known owners or differ from one in a single bit
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      idle_pct = idle_by_phase[ph];
      for (int n = 0; n < RANDOM_BINDS / NUM_PHASES; n++) begin
        pick = $urandom_range(99);
        if (known_ids.size() == 0 || pick < 55) begin
          who = {$urandom, $urandom};
          known_ids.push_back(who);
        end else begin
          who = known_ids[$urandom_range(known_ids.size() - 1)];
          if (pick < 70) who = who ^ (64'(1) << $urandom_range(63));
        end
        case ($urandom_range(9))
          0:       want = 8'd0;
          1:       want = 8'd255;
          2:       want = ID_LAST;
          3:       want = ID_FIRST;
          default: want = ID_W'($urandom_range(255));
        endcase
        send_bind(want, who);
      end
    end
    start <= 1'b0;

    while (id_table.grants_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("ran %0d bind transactions over %0d idle phases:",
             id_table.requests, NUM_PHASES);
    $display("  %0d new grants, %0d repeat grants, %0d refusals",
             id_table.fresh_grants, id_table.repeat_grants, id_table.refusals);
    if (id_table.full_at != 0)
      $display("id table ran full at transaction %0d", id_table.full_at);
    else
      $display("id table never ran full");
    if (id_table.mismatches == 0) begin
      $display("bus_node_id_binder_unit: match");
    end else begin
      $display("bus_node_id_binder_unit: mismatch");
    end
    $finish;
  end

endmodule
